### rtl/lcg_pkg.sv
// shared constants and types for the line colour gradient core
package lcg_pkg;

    localparam int DEF_WEIGHT_FRAC_BITS = 10;
    localparam int DEF_CHANNELS         = 4;
    localparam int DEF_COORD_BITS       = 16;

    localparam int SPAN_BITS  = 16;
    localparam int COLOR_BITS = 32;
    localparam int CHAN_BITS  = 8;
    localparam int CHAN_MAX   = 255;
    localparam int MAX_CHAN   = COLOR_BITS / CHAN_BITS;

    typedef struct packed {
        logic                  span_zero;
        logic [COLOR_BITS-1:0] color_start;
        logic [COLOR_BITS-1:0] color_end;
    } t_side;

endpackage

### rtl/lcg_dist.sv
// axis select, absolute distance and clamp to span, two register stages
module lcg_dist
    import lcg_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_major_is_x,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic [SPAN_BITS-1:0]         i_span_x,
    input  logic [SPAN_BITS-1:0]         i_span_y,
    input  logic [COLOR_BITS-1:0]        i_color_start,
    input  logic [COLOR_BITS-1:0]        i_color_end,
    output logic                         o_valid,
    output logic [SPAN_BITS-1:0]         o_dist,
    output logic [SPAN_BITS-1:0]         o_span,
    output t_side                        o_side
);

    localparam int CW = (COORD_BITS > SPAN_BITS) ? COORD_BITS : SPAN_BITS;

    logic                         r_a_valid;
    logic [COORD_BITS-1:0]        r_a_dist;
    logic [SPAN_BITS-1:0]         r_a_span;
    t_side                        r_a_side;
    logic [COORD_BITS-1:0]        n_a_dist;
    logic signed [COORD_BITS-1:0] sel_e;
    logic signed [COORD_BITS-1:0] sel_p;
    logic signed [COORD_BITS:0]   d_ep;
    logic signed [COORD_BITS:0]   d_pe;
    logic [SPAN_BITS-1:0]         sel_span;

    logic                         r_b_valid;
    logic [SPAN_BITS-1:0]         r_b_dist;
    logic [SPAN_BITS-1:0]         r_b_span;
    t_side                        r_b_side;
    logic [SPAN_BITS-1:0]         n_b_dist;
    logic [CW-1:0]                dist_ext;
    logic [CW-1:0]                span_ext;

    // stage a: exact distance on the chosen axis
    always_comb begin
        sel_e    = i_major_is_x ? i_end_x   : i_end_y;
        sel_p    = i_major_is_x ? i_point_x : i_point_y;
        sel_span = i_major_is_x ? i_span_x  : i_span_y;
        d_ep     = {sel_e[COORD_BITS-1], sel_e} - {sel_p[COORD_BITS-1], sel_p};
        d_pe     = {sel_p[COORD_BITS-1], sel_p} - {sel_e[COORD_BITS-1], sel_e};
        n_a_dist = d_ep[COORD_BITS] ? d_pe[COORD_BITS-1:0] : d_ep[COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_dist             <= n_a_dist;
        r_a_span             <= sel_span;
        r_a_side.span_zero   <= (sel_span == '0);
        r_a_side.color_start <= i_color_start;
        r_a_side.color_end   <= i_color_end;
    end

    // stage b: clamp distance to span
    always_comb begin
        dist_ext = CW'(r_a_dist);
        span_ext = CW'(r_a_span);
        n_b_dist = (dist_ext > span_ext) ? r_a_span : SPAN_BITS'(dist_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_dist <= n_b_dist;
        r_b_span <= r_a_span;
        r_b_side <= r_a_side;
    end

    assign o_valid = r_b_valid;
    assign o_dist  = r_b_dist;
    assign o_span  = r_b_span;
    assign o_side  = r_b_side;

endmodule

### rtl/lcg_div.sv
// pipelined restoring divider, one quotient bit per stage, dist <= span
module lcg_div
    import lcg_pkg::*;
#(
    parameter int FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [SPAN_BITS-1:0] i_dist,
    input  logic [SPAN_BITS-1:0] i_span,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_quot,
    output t_side                o_side
);

    logic                 r_vld  [0:FRAC_BITS];
    logic [SPAN_BITS-1:0] r_rem  [0:FRAC_BITS];
    logic [SPAN_BITS-1:0] r_span [0:FRAC_BITS];
    logic [FRAC_BITS:0]   r_quo  [0:FRAC_BITS];
    t_side                r_side [0:FRAC_BITS];

    for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_step
        logic                 vld_in;
        logic [SPAN_BITS-1:0] span_in;
        logic [FRAC_BITS:0]   quo_in;
        t_side                side_in;
        logic [SPAN_BITS:0]   trial;
        logic                 ge;
        logic [SPAN_BITS-1:0] n_rem;
        logic [FRAC_BITS:0]   n_quo;

        if (k == 0) begin : g_first
            always_comb begin
                vld_in  = i_valid;
                span_in = i_span;
                quo_in  = '0;
                side_in = i_side;
                trial   = {1'b0, i_dist};
            end
        end else begin : g_next
            always_comb begin
                vld_in  = r_vld[k-1];
                span_in = r_span[k-1];
                quo_in  = r_quo[k-1];
                side_in = r_side[k-1];
                trial   = {r_rem[k-1], 1'b0};
            end
        end

        always_comb begin
            ge    = (trial >= {1'b0, span_in});
            n_rem = ge ? SPAN_BITS'(trial - {1'b0, span_in}) : SPAN_BITS'(trial);
            n_quo = {quo_in[FRAC_BITS-1:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
            r_rem[k]  <= n_rem;
            r_span[k] <= span_in;
            r_quo[k]  <= n_quo;
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[FRAC_BITS];
    assign o_quot  = r_quo[FRAC_BITS];
    assign o_side  = r_side[FRAC_BITS];

endmodule

### rtl/lcg_blend.sv
// weight multiply per channel, then floor shift, add, cap and pack
module lcg_blend
    import lcg_pkg::*;
#(
    parameter int FRAC_BITS = DEF_WEIGHT_FRAC_BITS,
    parameter int CHANNELS  = DEF_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [FRAC_BITS:0]    i_quot,
    input  t_side                 i_side,
    output logic                  o_valid,
    output logic [COLOR_BITS-1:0] o_pixel_color
);

    localparam int NUM_CH = (CHANNELS < MAX_CHAN) ? CHANNELS : MAX_CHAN;
    localparam int PW     = CHAN_BITS + FRAC_BITS + 3;

    logic [FRAC_BITS:0]           weight;
    logic                         r_m_valid;
    logic signed [PW-1:0]         r_prod [0:NUM_CH-1];
    logic [CHAN_BITS-1:0]         r_base [0:NUM_CH-1];
    logic                         r_m_zero;
    logic [COLOR_BITS-1:0]        r_m_end;

    logic                         r_valid;
    logic [COLOR_BITS-1:0]        r_color;
    logic [COLOR_BITS-1:0]        n_color;

    assign weight = (FRAC_BITS+1)'(1) << FRAC_BITS;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_mul
        logic [CHAN_BITS-1:0]       a;
        logic [CHAN_BITS-1:0]       b;
        logic signed [CHAN_BITS:0]  diff;
        logic signed [FRAC_BITS+1:0] w_s;
        logic signed [PW-1:0]       n_prod;

        always_comb begin
            a      = i_side.color_start[c*CHAN_BITS +: CHAN_BITS];
            b      = i_side.color_end[c*CHAN_BITS +: CHAN_BITS];
            diff   = $signed({1'b0, b}) - $signed({1'b0, a});
            w_s    = $signed({1'b0, weight - i_quot});
            n_prod = PW'(diff) * PW'(w_s);
        end

        always_ff @(posedge i_clk) begin
            r_prod[c] <= n_prod;
            r_base[c] <= a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= i_valid;
        end
        r_m_zero <= i_side.span_zero;
        r_m_end  <= i_side.color_end;
    end

    // floor shift, add to start, cap to channel range; a zero span gives the end colour
    always_comb begin
        logic signed [PW-1:0] v;
        n_color = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            v = (r_prod[c] >>> FRAC_BITS) + $signed(PW'(r_base[c]));
            if (v < 0) begin
                n_color[c*CHAN_BITS +: CHAN_BITS] = '0;
            end else if (v > $signed(PW'(CHAN_MAX))) begin
                n_color[c*CHAN_BITS +: CHAN_BITS] = CHAN_BITS'(CHAN_MAX);
            end else begin
                n_color[c*CHAN_BITS +: CHAN_BITS] = v[CHAN_BITS-1:0];
            end
        end
        if (r_m_zero) begin
            n_color = r_m_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_m_valid;
        end
        r_color <= n_color;
    end

    assign o_valid       = r_valid;
    assign o_pixel_color = r_color;

endmodule

### rtl/line_color_gradient_core.sv
// top level of the line colour gradient core
//
// Colours one line pixel per beat. A beat is taken at every clock edge with start
// high; busy is held low, so a new pixel may follow in every cycle. The result
// appears on o_pixel_color with o_valid high for one cycle, in input order; the
// receiver must take it then. Each pixel passes two register stages for the
// distance, the divider that forms the weight, one quotient bit per register
// stage, and two stages for the channel blend. A zero span gives the end colour;
// a distance beyond the span gives the start colour.
module line_color_gradient_core
    import lcg_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS,
    parameter int CHANNELS         = DEF_CHANNELS,
    parameter int COORD_BITS       = DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_major_is_x,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic [SPAN_BITS-1:0]         i_span_x,
    input  logic [SPAN_BITS-1:0]         i_span_y,
    input  logic [COLOR_BITS-1:0]        i_color_start,
    input  logic [COLOR_BITS-1:0]        i_color_end,
    output logic                         o_valid,
    output logic [COLOR_BITS-1:0]        o_pixel_color
);

    logic                      d_valid;
    logic [SPAN_BITS-1:0]      d_dist;
    logic [SPAN_BITS-1:0]      d_span;
    t_side                     d_side;
    logic                      q_valid;
    logic [WEIGHT_FRAC_BITS:0] q_quot;
    t_side                     q_side;

    assign busy = 1'b0;

    lcg_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start),
        .i_major_is_x  (i_major_is_x),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_span_x      (i_span_x),
        .i_span_y      (i_span_y),
        .i_color_start (i_color_start),
        .i_color_end   (i_color_end),
        .o_valid       (d_valid),
        .o_dist        (d_dist),
        .o_span        (d_span),
        .o_side        (d_side)
    );

    lcg_div #(
        .FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_dist  (d_dist),
        .i_span  (d_span),
        .i_side  (d_side),
        .o_valid (q_valid),
        .o_quot  (q_quot),
        .o_side  (q_side)
    );

    lcg_blend #(
        .FRAC_BITS (WEIGHT_FRAC_BITS),
        .CHANNELS  (CHANNELS)
    ) u_blend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_quot        (q_quot),
        .i_side        (q_side),
        .o_valid       (o_valid),
        .o_pixel_color (o_pixel_color)
    );

endmodule

### dv/tb_line_color_gradient_core.sv
// self-checking testbench for the line colour gradient core
module tb_line_color_gradient_core;
    import lcg_pkg::*;

    localparam int WFB           = DEF_WEIGHT_FRAC_BITS;
    localparam int COORD_W       = DEF_COORD_BITS;
    localparam int LATENCY       = DEF_WEIGHT_FRAC_BITS + 5;
    localparam int QUIET_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 385;

    typedef struct {
        logic                      major_is_x;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [SPAN_BITS-1:0]      span_x;
        logic [SPAN_BITS-1:0]      span_y;
        logic [COLOR_BITS-1:0]     color_start;
        logic [COLOR_BITS-1:0]     color_end;
    } t_pixel_beat;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_major_is_x;
    logic signed [COORD_W-1:0] i_end_x;
    logic signed [COORD_W-1:0] i_end_y;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic [SPAN_BITS-1:0]      i_span_x;
    logic [SPAN_BITS-1:0]      i_span_y;
    logic [COLOR_BITS-1:0]     i_color_start;
    logic [COLOR_BITS-1:0]     i_color_end;
    logic                      o_valid;
    logic [COLOR_BITS-1:0]     o_pixel_color;

    t_pixel_beat           pixel_queue[$];
    logic [COLOR_BITS-1:0] colour_due[$];
    t_pixel_beat           next_beat;
    t_pixel_beat           seen_beat;
    logic [COLOR_BITS-1:0] want_colour;
    logic                  beat_taken;
    int                    sender_idle_pct;
    int                    fail_count;
    int                    quiet_cycles;

    line_color_gradient_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_major_is_x  (i_major_is_x),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_span_x      (i_span_x),
        .i_span_y      (i_span_y),
        .i_color_start (i_color_start),
        .i_color_end   (i_color_end),
        .o_valid       (o_valid),
        .o_pixel_color (o_pixel_color)
    );

    function automatic logic [COLOR_BITS-1:0] blend_colour(t_pixel_beat b);
        longint                e;
        longint                p;
        longint                gap;
        longint                span;
        longint                weight;
        longint                a;
        longint                c;
        longint                v;
        logic [COLOR_BITS-1:0] res;
        e    = b.major_is_x ? longint'(b.end_x) : longint'(b.end_y);
        p    = b.major_is_x ? longint'(b.point_x) : longint'(b.point_y);
        span = b.major_is_x ? longint'(b.span_x) : longint'(b.span_y);
        if (span == 0)
            return b.color_end;
        gap = (e >= p) ? e - p : p - e;
        if (gap > span)
            gap = span;
        weight = (longint'(1) << WFB) - ((gap << WFB) / span);
        res = '0;
        for (int ch = 0; ch < DEF_CHANNELS && ch < MAX_CHAN; ch++) begin
            a = longint'(b.color_start[ch*CHAN_BITS +: CHAN_BITS]);
            c = longint'(b.color_end[ch*CHAN_BITS +: CHAN_BITS]);
            v = a + (((c - a) * weight) >>> WFB);
            if (v > CHAN_MAX)
                v = CHAN_MAX;
            if (v < 0)
                v = 0;
            res[ch*CHAN_BITS +: CHAN_BITS] = v[CHAN_BITS-1:0];
        end
        return res;
    endfunction

    task automatic push_pixel(input logic major, input int ex, input int ey, input int px,
                              input int py, input int sx, input int sy,
                              input logic [COLOR_BITS-1:0] cs,
                              input logic [COLOR_BITS-1:0] ce);
        t_pixel_beat b;
        b.major_is_x  = major;
        b.end_x       = ex[COORD_W-1:0];
        b.end_y       = ey[COORD_W-1:0];
        b.point_x     = px[COORD_W-1:0];
        b.point_y     = py[COORD_W-1:0];
        b.span_x      = sx[SPAN_BITS-1:0];
        b.span_y      = sy[SPAN_BITS-1:0];
        b.color_start = cs;
        b.color_end   = ce;
        pixel_queue.push_back(b);
    endtask

    function automatic int pick_span();
        int mag;
        mag = $urandom_range(0, SPAN_BITS);
        if (mag == 0)
            return 1;
        return $urandom_range(1, (1 << mag) - 1);
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return $signed($urandom_range(0, 65535) - 32768);
        endcase
    endfunction

    function automatic logic [COLOR_BITS-1:0] pick_colour();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // point near the end point: within the span, or past it when reach is set
    function automatic int near_point(int e, int span, logic reach);
        int off;
        off = reach ? span + $urandom_range(1, 2000) : $urandom_range(0, span);
        if ($urandom_range(0, 1) && e + off <= 32767)
            return e + off;
        if (e - off >= -32768)
            return e - off;
        return e + off;
    endfunction

    task automatic push_random_pixel();
        logic                  major;
        int                    ex;
        int                    ey;
        int                    sx;
        int                    sy;
        int                    kind;
        logic [COLOR_BITS-1:0] cs;
        logic [COLOR_BITS-1:0] ce;
        major = 1'($urandom_range(0, 1));
        ex    = $signed($urandom_range(0, 65535) - 32768);
        ey    = $signed($urandom_range(0, 65535) - 32768);
        sx    = pick_span();
        sy    = pick_span();
        cs    = pick_colour();
        ce    = ($urandom_range(0, 9) == 0) ? cs : pick_colour();
        kind  = $urandom_range(0, 9);
        case (kind)
            6: push_pixel(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            7: push_pixel(major, ex, ey, near_point(ex, sx, 1'b0), near_point(ey, sy, 1'b0),
                          (major || $urandom_range(0, 1)) ? 0 : sx,
                          (!major || $urandom_range(0, 1)) ? 0 : sy, cs, ce);
            8: begin
                sx = $urandom_range(1, 300);
                sy = $urandom_range(1, 300);
                push_pixel(major, ex, ey, near_point(ex, sx, 1'b1), near_point(ey, sy, 1'b1),
                           sx, sy, cs, ce);
            end
            9: push_pixel(major, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                          $urandom_range(0, 1) ? 65535 : $urandom_range(0, 2),
                          $urandom_range(0, 1) ? 65535 : $urandom_range(0, 2), cs, ce);
            default: push_pixel(major, ex, ey, near_point(ex, sx, 1'b0),
                                near_point(ey, sy, 1'b0), sx, sy, cs, ce);
        endcase
    endtask

    // every queued beat taken, then every colour back
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pixel_queue.size() != 0 || start);
        while (colour_due.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || beat_taken) begin
            if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                next_beat = pixel_queue.pop_front();
                i_major_is_x  <= next_beat.major_is_x;
                i_end_x       <= next_beat.end_x;
                i_end_y       <= next_beat.end_y;
                i_point_x     <= next_beat.point_x;
                i_point_y     <= next_beat.point_y;
                i_span_x      <= next_beat.span_x;
                i_span_y      <= next_beat.span_y;
                i_color_start <= next_beat.color_start;
                i_color_end   <= next_beat.color_end;
                start         <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        beat_taken = i_rst_n && start && !busy;
        if (beat_taken) begin
            seen_beat.major_is_x  = i_major_is_x;
            seen_beat.end_x       = i_end_x;
            seen_beat.end_y       = i_end_y;
            seen_beat.point_x     = i_point_x;
            seen_beat.point_y     = i_point_y;
            seen_beat.span_x      = i_span_x;
            seen_beat.span_y      = i_span_y;
            seen_beat.color_start = i_color_start;
            seen_beat.color_end   = i_color_end;
            colour_due.push_back(blend_colour(seen_beat));
        end
        if (i_rst_n && o_valid) begin
            if (colour_due.size() == 0) begin
                $error("pixel_color: expected none, got %08h", o_pixel_color);
                fail_count++;
            end else begin
                want_colour = colour_due.pop_front();
                if (o_pixel_color !== want_colour) begin
                    $error("pixel_color: expected %08h, got %08h", want_colour, o_pixel_color);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || beat_taken || o_valid)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_major_is_x    = 1'b0;
        i_end_x         = '0;
        i_end_y         = '0;
        i_point_x       = '0;
        i_point_y       = '0;
        i_span_x        = '0;
        i_span_y        = '0;
        i_color_start   = '0;
        i_color_end     = '0;
        beat_taken      = 1'b0;
        sender_idle_pct = 0;
        fail_count      = 0;
        quiet_cycles    = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero span on either axis
        push_pixel(1'b1, 0, 0, 0, 0, 0, 5, 32'h11223344, 32'hAABBCCDD);
        push_pixel(1'b0, 0, 0, 0, 0, 7, 0, 32'h11223344, 32'hAABBCCDD);
        // at the end point, one span away, beyond the span
        push_pixel(1'b1, 100, 0, 100, 0, 1, 1, 32'h00000000, 32'hFFFFFFFF);
        push_pixel(1'b1, 100, 0, 90, 0, 10, 1, 32'h01020304, 32'hF0E0D0C0);
        push_pixel(1'b0, 0, -50, 0, 50, 3, 10, 32'hFFFFFFFF, 32'h00000000);
        // widest distances and spans, no wrap
        push_pixel(1'b1, -32768, 0, 32767, 0, 65535, 0, 32'h12345678, 32'h9ABCDEF0);
        push_pixel(1'b1, 32767, 0, -32768, 0, 100, 0, 32'h12345678, 32'h9ABCDEF0);
        push_pixel(1'b0, 0, 32767, 0, 32766, 0, 65535, 32'hFFFFFFFF, 32'h00000000);
        // halfway, rising and falling channels, then assorted mixes
        push_pixel(1'b1, 0, 0, 5, 0, 10, 0, 32'h00000000, 32'hFFFFFFFF);
        push_pixel(1'b1, 0, 0, 5, 0, 10, 0, 32'hFFFFFFFF, 32'h00000000);
        push_pixel(1'b0, 1234, -7, -999, -8, 0, 3, 32'h80808080, 32'h7F7F7F7F);
        push_pixel(1'b0, -1, -32768, -1, -32767, 65535, 2, 32'h00FF00FF, 32'hFF00FF00);
        push_pixel(1'b1, 32767, 32767, 32767, 32767, 65535, 65535, 32'hFFFFFFFF,
                   32'hFFFFFFFF);
        push_pixel(1'b0, -32768, -32768, -32768, 32767, 65535, 65535, 32'h12345678,
                   32'h87654321);
        push_pixel(1'b1, 7, 0, 0, 0, 3, 0, 32'h01FE7F80, 32'hFE01807F);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1: sender_idle_pct = 78;
                3: sender_idle_pct = 16;
                default: sender_idle_pct = 0;
            endcase
            repeat (PHASE_ITEMS) push_random_pixel();
            wait_drained();
            @(posedge i_clk);
        end

        repeat (2 * LATENCY) @(negedge i_clk);
        if (fail_count == 0 && colour_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
